// ----- rtl/core/mwbm_pkg.sv -----
// ----------------------------------------------------------------------------
// mwbm_pkg
// Shared widths, reset values and types of the multi-window bitrate meter.
// ----------------------------------------------------------------------------
`default_nettype none

package mwbm_pkg;

  localparam int TIME_WIDTH = 48;
  localparam int BYTE_WIDTH = 48;
  localparam int NWIN       = 4;
  localparam int LEN_W      = 32;
  localparam int RATE_W     = 31;
  localparam int MASK_W     = NWIN;
  localparam int CFG_IDX_W  = 3;

  localparam int WIN_W      = $clog2(NWIN);
  // dividend is the byte delta times eight
  localparam int DIVIDEND_W = BYTE_WIDTH + 3;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam int IN_DATA_W  = ((TIME_WIDTH + BYTE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((NWIN * RATE_W + MASK_W + 7) / 8) * 8;

  typedef logic [WIN_W-1:0]     win_idx_t;
  typedef logic [DIV_CNT_W-1:0] div_cnt_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [RATE_W-1:0]    rate_t;

  localparam win_idx_t LAST_WIN = win_idx_t'(NWIN - 1);
  localparam div_cnt_t DIV_LAST = div_cnt_t'(DIVIDEND_W - 1);
  localparam rate_t    RATE_MAX = {RATE_W{1'b1}};

  localparam len_t LEN0_RST = len_t'(30 * 1000);
  localparam len_t LEN1_RST = len_t'(60 * 1000);
  localparam len_t LEN2_RST = len_t'(300 * 1000);
  localparam len_t LEN3_RST = len_t'(3600 * 1000);

  // one window entry of the state memory
  typedef struct packed {
    rate_t                 rate;
    logic [BYTE_WIDTH-1:0] start_bytes;
    logic [TIME_WIDTH-1:0] base_time;
  } win_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/multi_window_bitrate_meter_top.sv -----
// ----------------------------------------------------------------------------
// multi_window_bitrate_meter_top
// Four-window bitrate meter with window state in a one-port-read memory and
// one shared restoring divider.
// ----------------------------------------------------------------------------
// each window is read, evaluated and decided in turn; a window that closes with a
//   rising byte count also runs 51 divider steps over byte_delta*8
// one sample at a time: s_tready is high only in S_IDLE
// reset: rst clears all windows to invalid and loads the default lengths
// ----------------------------------------------------------------------------
`default_nettype none

module multi_window_bitrate_meter_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // config write port
  input  wire logic                           cfg_we,
  input  wire logic [mwbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mwbm_pkg::LEN_W-1:0]     cfg_data,
  // sample stream
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  // s_tdata: now_ms, byte_count
  input  wire logic [mwbm_pkg::IN_DATA_W-1:0] s_tdata,
  // result stream
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  // m_tdata: rate0_kbps, rate1_kbps, rate2_kbps, rate3_kbps, updated_mask
  output      logic [mwbm_pkg::OUT_DATA_W-1:0] m_tdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EVAL, S_DECIDE, S_DIV, S_FIN, S_WRITE, S_DONE
  } state_t;

  localparam int TW = mwbm_pkg::TIME_WIDTH;
  localparam int BW = mwbm_pkg::BYTE_WIDTH;

  state_t                    state;
  mwbm_pkg::win_idx_t        idx;
  mwbm_pkg::len_t            win_len [mwbm_pkg::NWIN];
  logic [mwbm_pkg::NWIN-1:0] win_valid;
  mwbm_pkg::rate_t           rates [mwbm_pkg::NWIN];
  logic [mwbm_pkg::MASK_W-1:0] mask;

  logic [TW-1:0] now_r;
  logic [BW-1:0] total_r;

  // state memory
  mwbm_pkg::win_entry_t mem [mwbm_pkg::NWIN];
  mwbm_pkg::win_entry_t rd_data;
  mwbm_pkg::win_entry_t wr_data;
  logic                 mem_we;

  // evaluation results
  logic [TW-1:0]   elapsed;
  logic [BW-1:0]   delta;
  logic            time_fwd;
  logic            bytes_ok;
  mwbm_pkg::rate_t rate_new;

  // divider
  logic [mwbm_pkg::DIVIDEND_W-1:0] dvd;
  logic [mwbm_pkg::DIVIDEND_W-1:0] quo;
  logic [TW-1:0]                   rem;
  logic [TW-1:0]                   dvs;
  mwbm_pkg::div_cnt_t              cnt;
  logic [TW:0]                     rem_shift;
  logic [TW:0]                     rem_diff;

  logic close_win;

  assign s_tready  = (state == S_IDLE);
  assign mem_we    = (state == S_WRITE);
  assign wr_data   = '{rate: rate_new, start_bytes: total_r, base_time: now_r};
  assign rem_shift = {rem, dvd[mwbm_pkg::DIVIDEND_W-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs};
  assign close_win = time_fwd && (elapsed > {{(TW - mwbm_pkg::LEN_W){1'b0}}, win_len[idx]});

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_data <= mem[idx];
    end
    if (mem_we) begin
      mem[idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      win_valid  <= '0;
      m_tvalid   <= 1'b0;
      mask       <= '0;
      win_len[0] <= mwbm_pkg::LEN0_RST;
      win_len[1] <= mwbm_pkg::LEN1_RST;
      win_len[2] <= mwbm_pkg::LEN2_RST;
      win_len[3] <= mwbm_pkg::LEN3_RST;
    end else begin
      if (cfg_we && (cfg_index < mwbm_pkg::CFG_IDX_W'(mwbm_pkg::NWIN))) begin
        win_len[cfg_index[mwbm_pkg::WIN_W-1:0]] <= cfg_data;
      end
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            now_r   <= s_tdata[TW-1:0];
            total_r <= s_tdata[TW+BW-1:TW];
            mask    <= '0;
            idx     <= '0;
            state   <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          elapsed  <= now_r - rd_data.base_time;
          delta    <= total_r - rd_data.start_bytes;
          time_fwd <= now_r > rd_data.base_time;
          bytes_ok <= total_r >= rd_data.start_bytes;
          state    <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!win_valid[idx]) begin
            rate_new  <= '0;
            mask[idx] <= 1'b1;
            state     <= S_WRITE;
          end else if (close_win) begin
            mask[idx] <= 1'b1;
            if (bytes_ok) begin
              dvd   <= {delta, 3'b000};
              dvs   <= elapsed;
              rem   <= '0;
              quo   <= '0;
              cnt   <= '0;
              state <= S_DIV;
            end else begin
              rate_new <= '0;
              state    <= S_WRITE;
            end
          end else begin
            // window keeps running, report its last rate
            rates[idx] <= rd_data.rate;
            idx        <= idx + 1'b1;
            state      <= (idx == mwbm_pkg::LAST_WIN) ? S_DONE : S_READ;
          end
        end
        S_DIV: begin
          // restoring step, one quotient bit a cycle
          if (!rem_diff[TW]) begin
            rem <= rem_diff[TW-1:0];
            quo <= {quo[mwbm_pkg::DIVIDEND_W-2:0], 1'b1};
          end else begin
            rem <= rem_shift[TW-1:0];
            quo <= {quo[mwbm_pkg::DIVIDEND_W-2:0], 1'b0};
          end
          dvd <= {dvd[mwbm_pkg::DIVIDEND_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == mwbm_pkg::DIV_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (|quo[mwbm_pkg::DIVIDEND_W-1:mwbm_pkg::RATE_W]) begin
            rate_new <= mwbm_pkg::RATE_MAX;
          end else begin
            rate_new <= quo[mwbm_pkg::RATE_W-1:0];
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          win_valid[idx] <= 1'b1;
          rates[idx]     <= rate_new;
          idx            <= idx + 1'b1;
          state          <= (idx == mwbm_pkg::LAST_WIN) ? S_DONE : S_READ;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {mask, rates[3], rates[2], rates[1], rates[0]};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
